// ----- hw/rtl/dhkv_pkg.sv -----
package dhkv_pkg;

  // fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEARCH = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY    = 2'd0,
    SLOT_OCCUPIED = 2'd1,
    SLOT_DELETED  = 2'd2
  } slot_state_e;

  // one table entry as held in the slot memory
  typedef struct packed {
    slot_state_e           state;
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
  } entry_t;

endpackage

// ----- hw/rtl/dhkv_cmd_if.sv -----
interface dhkv_cmd_if;
  import dhkv_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

// ----- hw/rtl/dhkv_rsp_if.sv -----
interface dhkv_rsp_if;
  import dhkv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [VAL_W-1:0]      found_value;
  logic [SLOT_OUT_W-1:0] slot;

  modport source (output valid, output status, output found_value, output slot, input ready);
  modport sink   (input valid, input status, input found_value, input slot, output ready);
endinterface

// ----- hw/rtl/dhkv_ram.sv -----
module dhkv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/dhkv_mod_unit.sv -----
module dhkv_mod_unit #(
  parameter int unsigned TABLE_SLOTS = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dhkv_pkg::KEY_W-1:0]     key_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0] rem_m_o,
  output logic [$clog2(TABLE_SLOTS)-1:0] rem_m1_o
);
  import dhkv_pkg::*;

  localparam int unsigned RemW  = $clog2(TABLE_SLOTS);
  localparam int unsigned MulBW = 32;
  localparam int unsigned ProdW = KEY_W + MulBW;
  // rounded-up reciprocals, exact quotient for every key below 2**KEY_W
  localparam int unsigned ShM   = KEY_W + $clog2(TABLE_SLOTS);
  localparam int unsigned ShM1  = KEY_W + $clog2(TABLE_SLOTS - 1);
  localparam logic [63:0] RecipMWide  =
    ((64'd1 << ShM) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
  localparam logic [63:0] RecipM1Wide =
    ((64'd1 << ShM1) + 64'(TABLE_SLOTS) - 64'd2) / 64'(TABLE_SLOTS - 1);
  localparam logic [MulBW-1:0] RecipM  = RecipMWide[MulBW-1:0];
  localparam logic [MulBW-1:0] RecipM1 = RecipM1Wide[MulBW-1:0];
  localparam logic [MulBW-1:0] DivM    = MulBW'(TABLE_SLOTS);
  localparam logic [MulBW-1:0] DivM1   = MulBW'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_QUO_M,
    PH_REM_M,
    PH_QUO_M1,
    PH_REM_M1
  } phase_e;

  phase_e              phase_q;
  logic                done_q;
  logic [KEY_W-1:0]    key_q;
  logic [KEY_W-1:0]    quo_q;
  logic [RemW-1:0]     rem_m_q;
  logic [RemW-1:0]     rem_m1_q;

  // shared multiplier
  logic [KEY_W-1:0]    mul_a;
  logic [MulBW-1:0]    mul_b;
  logic [ProdW-1:0]    prod;
  logic [KEY_W-1:0]    diff;

  // operand select: key times reciprocal, then quotient times divisor
  always_comb begin
    case (phase_q)
      PH_QUO_M: begin
        mul_a = key_q;
        mul_b = RecipM;
      end
      PH_REM_M: begin
        mul_a = quo_q;
        mul_b = DivM;
      end
      PH_QUO_M1: begin
        mul_a = key_q;
        mul_b = RecipM1;
      end
      PH_REM_M1: begin
        mul_a = quo_q;
        mul_b = DivM1;
      end
      default: begin
        mul_a = key_q;
        mul_b = '0;
      end
    endcase
  end

  assign prod = ProdW'(mul_a) * ProdW'(mul_b);
  // quotient times divisor never exceeds the key
  assign diff = key_q - prod[KEY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      done_q   <= 1'b0;
      key_q    <= '0;
      quo_q    <= '0;
      rem_m_q  <= '0;
      rem_m1_q <= '0;
    end else if (start_i) begin
      phase_q <= PH_QUO_M;
      done_q  <= 1'b0;
      key_q   <= key_i;
    end else begin
      done_q <= (phase_q == PH_REM_M1);
      case (phase_q)
        PH_QUO_M: begin
          quo_q   <= KEY_W'(prod >> ShM);
          phase_q <= PH_REM_M;
        end
        PH_REM_M: begin
          rem_m_q <= diff[RemW-1:0];
          phase_q <= PH_QUO_M1;
        end
        PH_QUO_M1: begin
          quo_q   <= KEY_W'(prod >> ShM1);
          phase_q <= PH_REM_M1;
        end
        PH_REM_M1: begin
          rem_m1_q <= diff[RemW-1:0];
          phase_q  <= PH_IDLE;
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign rem_m_o  = rem_m_q;
  assign rem_m1_o = rem_m1_q;

endmodule

// ----- hw/rtl/double_hash_key_value_table_top.sv -----
// sequence: command transfer, remainder unit, then per probe p (1..slots) a slot read and a check,
// then the output register; insert on a full table and the unused command skip hash and probes
// throughput: one command at a time, the next taken only once the output register is loaded;
// the 4-pass remainder unit on one shared multiplier and the probe walk set the pace
// reset: async active low; then a clearing pass writes each of the TABLE_SLOTS slots empty,
// during which no command is taken
module double_hash_key_value_table_top #(
  parameter int unsigned TABLE_SLOTS = 31
) (
  input logic        clk_i,
  input logic        rst_ni,
  dhkv_cmd_if.sink   cmd_i,
  dhkv_rsp_if.source rsp_o
);
  import dhkv_pkg::*;

  localparam int unsigned SlotW  = $clog2(TABLE_SLOTS);
  localparam int unsigned CntW   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned EntryW = $bits(entry_t);
  localparam logic [SlotW-1:0] LastSlot  = SlotW'(TABLE_SLOTS - 1);
  localparam logic [SlotW:0]   SlotsWide = (SlotW + 1)'(TABLE_SLOTS);
  localparam logic [CntW-1:0]  FullCount = CntW'(TABLE_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  // sequencer state
  state_e            state_q;
  logic [SlotW-1:0]  clr_q;
  logic [CntW-1:0]   count_q;

  // command being worked on
  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;

  // probe walk
  logic [SlotW-1:0]  h_q;
  logic [SlotW-1:0]  step_q;
  logic [SlotW-1:0]  probe_q;
  logic              have_free_q;
  logic [SlotW-1:0]  free_q;

  // finished result, then the output register
  status_e           res_status_q;
  logic [VAL_W-1:0]  res_value_q;
  logic [SlotW-1:0]  res_slot_q;
  logic              rsp_valid_q;
  status_e           rsp_status_q;
  logic [VAL_W-1:0]  rsp_value_q;
  logic [SlotW-1:0]  rsp_slot_q;

  // remainder unit
  logic              cmd_xfer;
  logic              hash_done;
  logic [SlotW-1:0]  rem_m;
  logic [SlotW-1:0]  rem_m1;

  // slot memory
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  entry_t            rd;

  // check-stage decisions
  logic              fin;
  status_e           fin_status;
  logic [VAL_W-1:0]  fin_value;
  logic [SlotW-1:0]  fin_slot;
  logic              cnt_inc;
  logic              cnt_dec;
  logic              note_free;
  logic [SlotW:0]    next_sum;
  logic [SlotW-1:0]  next_h;

  assign cmd_xfer = cmd_i.valid && cmd_i.ready;
  assign rd       = entry_t'(ram_rdata);

  dhkv_mod_unit #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_mod_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_xfer),
    .key_i    (cmd_i.key),
    .done_o   (hash_done),
    .rem_m_o  (rem_m),
    .rem_m1_o (rem_m1)
  );

  dhkv_ram #(
    .WIDTH(EntryW),
    .DEPTH(TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (h_q),
    .rdata_o (ram_rdata)
  );

  // next probe slot: both terms below the slot count, one subtract at most
  always_comb begin
    next_sum = {1'b0, h_q} + {1'b0, step_q};
    if (next_sum >= SlotsWide) begin
      next_sum = next_sum - SlotsWide;
    end
    next_h = next_sum[SlotW-1:0];
  end

  // check stage: look at the slot just read and decide
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = h_q;
    ram_wdata  = '{state: SLOT_OCCUPIED, key: key_q, value: val_q};
    fin        = 1'b0;
    fin_status = ST_NOT_FOUND;
    fin_value  = '0;
    fin_slot   = '0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    note_free  = 1'b0;
    if (state_q == S_CLEAR) begin
      // clearing pass after reset
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '{state: SLOT_EMPTY, key: '0, value: '0};
    end else if (state_q == S_CHECK) begin
      case (cmd_q)
        CMD_SEARCH, CMD_REMOVE: begin
          if (rd.state == SLOT_EMPTY) begin
            fin = 1'b1;
          end else if (rd.state == SLOT_OCCUPIED && rd.key == key_q) begin
            fin        = 1'b1;
            fin_status = ST_OK;
            fin_slot   = h_q;
            if (cmd_q == CMD_SEARCH) begin
              fin_value = rd.value;
            end else begin
              // tombstone keeps other probe chains intact
              ram_we          = 1'b1;
              ram_wdata.state = SLOT_DELETED;
              ram_wdata.value = '0;
              cnt_dec         = 1'b1;
            end
          end else if (probe_q == LastSlot) begin
            fin = 1'b1;
          end
        end
        CMD_INSERT: begin
          if (rd.state == SLOT_OCCUPIED && rd.key == key_q) begin
            // update in place
            fin        = 1'b1;
            fin_status = ST_OK;
            fin_slot   = h_q;
            ram_we     = 1'b1;
          end else if (rd.state == SLOT_EMPTY || (probe_q == LastSlot &&
                       (have_free_q || rd.state == SLOT_DELETED))) begin
            // place at first free slot seen on the chain
            fin        = 1'b1;
            fin_status = ST_OK;
            fin_slot   = have_free_q ? free_q : h_q;
            ram_we     = 1'b1;
            ram_waddr  = have_free_q ? free_q : h_q;
            cnt_inc    = 1'b1;
          end else if (probe_q == LastSlot) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
          end else begin
            note_free = !have_free_q && rd.state == SLOT_DELETED;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      count_q      <= '0;
      cmd_q        <= '0;
      key_q        <= '0;
      val_q        <= '0;
      h_q          <= '0;
      step_q       <= '0;
      probe_q      <= '0;
      have_free_q  <= 1'b0;
      free_q       <= '0;
      res_status_q <= ST_NOT_FOUND;
      res_value_q  <= '0;
      res_slot_q   <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= ST_NOT_FOUND;
      rsp_value_q  <= '0;
      rsp_slot_q   <= '0;
    end else begin
      // a finished result refills the output register, a response transfer frees it
      if (state_q == S_DONE && (!rsp_valid_q || rsp_o.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LastSlot) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_i.valid) begin
            cmd_q        <= cmd_i.command;
            key_q        <= cmd_i.key;
            val_q        <= cmd_i.value;
            probe_q      <= '0;
            have_free_q  <= 1'b0;
            res_status_q <= ST_NOT_FOUND;
            res_value_q  <= '0;
            res_slot_q   <= '0;
            if (cmd_i.command == CMD_INSERT && count_q >= FullCount) begin
              // full table refuses inserts, even updates
              res_status_q <= ST_FULL;
              state_q      <= S_DONE;
            end else if (cmd_i.command inside {CMD_SEARCH, CMD_INSERT, CMD_REMOVE}) begin
              state_q <= S_HASH;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            h_q     <= rem_m;
            step_q  <= rem_m1 + 1'b1;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (fin) begin
            res_status_q <= fin_status;
            res_value_q  <= fin_value;
            res_slot_q   <= fin_slot;
            if (cnt_inc) begin
              count_q <= count_q + 1'b1;
            end else if (cnt_dec && count_q != '0) begin
              count_q <= count_q - 1'b1;
            end
            state_q <= S_DONE;
          end else begin
            if (note_free) begin
              have_free_q <= 1'b1;
              free_q      <= h_q;
            end
            h_q     <= next_h;
            probe_q <= probe_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_status_q <= res_status_q;
            rsp_value_q  <= res_value_q;
            rsp_slot_q   <= res_slot_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_value = rsp_value_q;
  assign rsp_o.slot        = SLOT_OUT_W'(rsp_slot_q);

endmodule

// ----- hw/rtl/dhkv_checker.sv -----
module dhkv_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cmd_valid_i,
  input logic                            cmd_ready_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [dhkv_pkg::STATUS_W-1:0]   rsp_status_i,
  input logic [dhkv_pkg::VAL_W-1:0]      rsp_value_i,
  input logic [dhkv_pkg::SLOT_OUT_W-1:0] rsp_slot_i
);
  import dhkv_pkg::*;

  // no response on the cycle after a reset cycle
  a_rsp_idle_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !rsp_valid_i)
    else $error("response valid during reset");

  // a stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
    $stable(rsp_value_i) && $stable(rsp_slot_i))
    else $error("stalled response changed");

  // failed commands carry zero value and slot
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_value_i == '0 && rsp_slot_i == '0)
    else $error("nonzero fields on failed command");

  // block is busy right after taking a command
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("ready right after command transfer");

endmodule

bind double_hash_key_value_table_top dhkv_checker u_dhkv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_value_i  (rsp_o.found_value),
  .rsp_slot_i   (rsp_o.slot)
);

// ----- dv/testbench.sv -----
module testbench;
  import dhkv_pkg::*;

  // table geometry, must match the block parameter (prime)
  localparam int unsigned SLOTS     = 31;
  // cycle budget: ~570 commands plus the long hold, many times over
  localparam int unsigned LIMIT     = 600000;
  // receiver hold-off, well beyond the longest probe run
  localparam int unsigned LONG_HOLD = 400;
  // quiet cycles after the last reply, longer than a full-length probe run
  localparam int unsigned TAIL      = 150;
  // the one command code the block does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // largest key the bench drives
  localparam logic [KEY_W-1:0] KEY_MAX    = 31'h7FFF_FFFE;

  // one command as queued for the driver; drain makes the driver wait for all replies first
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             drain;
  } table_op_t;

  // one reply as the block should return it
  typedef struct packed {
    status_e               status;
    logic [VAL_W-1:0]      found_value;
    logic [SLOT_OUT_W-1:0] slot;
  } table_reply_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cmd_valid = 1'b0;
  table_op_t cmd_cur   = '0;
  logic      rsp_ready = 1'b0;
  // high for the cycle after a command transfer, so the driver knows it may move on
  logic      cmd_fire  = 1'b0;

  dhkv_cmd_if cmd_bus ();
  dhkv_rsp_if rsp_bus ();

  assign cmd_bus.valid   = cmd_valid;
  assign cmd_bus.command = cmd_cur.command;
  assign cmd_bus.key     = cmd_cur.key;
  assign cmd_bus.value   = cmd_cur.value;
  assign rsp_bus.ready   = rsp_ready;

  double_hash_key_value_table_top #(
    .TABLE_SLOTS(SLOTS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_bus),
    .rsp_o (rsp_bus)
  );

  // mirror of the table contents, updated in command transfer order
  logic [KEY_W-1:0] mirror_key   [SLOTS];
  logic [VAL_W-1:0] mirror_value [SLOTS];
  slot_state_e      mirror_state [SLOTS];
  int unsigned      mirror_count;

  table_op_t    op_backlog[$];       // commands not yet offered
  table_reply_t awaited_replies[$];  // predicted replies, oldest first

  int unsigned ops_total    = 0;
  int unsigned ops_accepted = 0;
  int unsigned rsp_count    = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;

  // sender burst/gap shaping
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  // receiver stall shaping
  logic [7:0]  ready_phase = '0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // walk the probe chain of a key; stops at an empty slot, a match, or after SLOTS probes
  function automatic bit mirror_find(input logic [KEY_W-1:0] k, output int unsigned where);
    int unsigned h, step, i;
    bit hit, stop;
    h     = {1'b0, k} % SLOTS;
    step  = 1 + {1'b0, k} % (SLOTS - 1);
    hit   = 1'b0;
    stop  = 1'b0;
    where = 0;
    for (i = 0; i < SLOTS && !stop; i++) begin
      if (mirror_state[h] == SLOT_EMPTY) begin
        stop = 1'b1;
      end else if (mirror_state[h] == SLOT_OCCUPIED && mirror_key[h] == k) begin
        hit   = 1'b1;
        stop  = 1'b1;
        where = h;
      end else begin
        h = (h + step) % SLOTS;
      end
    end
    return hit;
  endfunction

  // apply one command to the mirror and return the reply it should produce
  function automatic table_reply_t table_predict(input table_op_t op);
    table_reply_t r;
    int unsigned h, step, i, free_slot;
    bit have_free, hit, stop;
    r.status      = ST_NOT_FOUND;
    r.found_value = '0;
    r.slot        = '0;
    case (op.command)
      CMD_SEARCH: begin
        if (mirror_find(op.key, h)) begin
          r.status      = ST_OK;
          r.found_value = mirror_value[h];
          r.slot        = h[SLOT_OUT_W-1:0];
        end
      end
      CMD_INSERT: begin
        // a full table refuses every insert, even an update of a present key
        if (mirror_count >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          h         = {1'b0, op.key} % SLOTS;
          step      = 1 + {1'b0, op.key} % (SLOTS - 1);
          have_free = 1'b0;
          hit       = 1'b0;
          stop      = 1'b0;
          free_slot = 0;
          for (i = 0; i < SLOTS && !stop; i++) begin
            if (mirror_state[h] == SLOT_OCCUPIED && mirror_key[h] == op.key) begin
              hit  = 1'b1;
              stop = 1'b1;
            end else begin
              // first deleted or empty slot on the chain takes a new key
              if (mirror_state[h] != SLOT_OCCUPIED && !have_free) begin
                free_slot = h;
                have_free = 1'b1;
              end
              if (mirror_state[h] == SLOT_EMPTY) stop = 1'b1;
              else h = (h + step) % SLOTS;
            end
          end
          if (hit) begin
            mirror_value[h] = op.value;
            r.status        = ST_OK;
            r.slot          = h[SLOT_OUT_W-1:0];
          end else if (have_free) begin
            mirror_key[free_slot]   = op.key;
            mirror_value[free_slot] = op.value;
            mirror_state[free_slot] = SLOT_OCCUPIED;
            mirror_count++;
            r.status = ST_OK;
            r.slot   = free_slot[SLOT_OUT_W-1:0];
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      CMD_REMOVE: begin
        // removal leaves a deleted marker so other chains stay intact
        if (mirror_find(op.key, h)) begin
          mirror_state[h] = SLOT_DELETED;
          mirror_value[h] = '0;
          if (mirror_count > 0) mirror_count--;
          r.status = ST_OK;
          r.slot   = h[SLOT_OUT_W-1:0];
        end
      end
      default: begin
        // unused command: no change, not found
      end
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'($urandom_range(0, KEY_MAX));
  endfunction

  task automatic queue_op(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v, input bit hold);
    table_op_t op;
    op.command = cmd;
    op.key     = k;
    op.value   = v;
    op.drain   = hold;
    op_backlog.insert(op_backlog.size(), op);
  endtask

  // random traffic on a small pool of colliding keys, then the pool is cleared out
  task automatic add_mixed_phase(input int unsigned n_ops);
    logic [KEY_W-1:0] pool [12];
    logic [KEY_W-1:0] base, k;
    logic [CMD_W-1:0] cmd;
    int unsigned j, pick;
    base = KEY_W'($urandom_range(0, 32'h7FFF_0000));
    for (j = 0; j < 12; j++) begin
      // same first slot with different steps, identical chains, and unrelated keys
      if (j < 6)      pool[j] = base + KEY_W'(31 * j);
      else if (j < 9) pool[j] = base + KEY_W'(930 * (j - 5));
      else            pool[j] = rand_key();
    end
    if ($urandom_range(0, 3) == 0) begin
      pool[9]  = '0;
      pool[10] = KEY_MAX;
    end
    for (j = 0; j < n_ops; j++) begin
      k    = ($urandom_range(0, 9) == 0) ? rand_key() : pool[$urandom_range(0, 11)];
      pick = $urandom_range(0, 99);
      if (pick < 45)      cmd = CMD_INSERT;
      else if (pick < 75) cmd = CMD_SEARCH;
      else if (pick < 98) cmd = CMD_REMOVE;
      else                cmd = CMD_UNUSED;
      // each phase opens with the sender waiting until the table has answered everything
      queue_op(cmd, k, $urandom(), j == 0);
    end
    for (j = 0; j < 12; j++) queue_op(CMD_REMOVE, pool[j], $urandom(), 1'b0);
  endtask

  // drive the table to capacity and beyond, then empty it again
  task automatic add_fill_phase();
    logic [KEY_W-1:0] filled[$];
    logic [KEY_W-1:0] k;
    int unsigned j;
    // fresh random keys: they land until the table is full, the rest see a full table
    for (j = 0; j < 36; j++) begin
      k = rand_key();
      filled.insert(filled.size(), k);
      queue_op(CMD_INSERT, k, $urandom(), j == 0);
    end
    // full table refuses present keys too
    repeat (5) queue_op(CMD_INSERT, filled[$urandom_range(0, filled.size() - 1)], $urandom(),
                        1'b0);
    // no empty slot anywhere: a miss runs the whole probe sequence
    repeat (5) queue_op(CMD_SEARCH, rand_key(), $urandom(), 1'b0);
    repeat (5) queue_op(CMD_SEARCH, filled[$urandom_range(0, filled.size() - 1)], $urandom(),
                        1'b0);
    repeat (10) queue_op(CMD_REMOVE, filled[$urandom_range(0, filled.size() - 1)], $urandom(),
                         1'b0);
    // mix of occupied and deleted slots only
    repeat (5) queue_op(CMD_SEARCH, rand_key(), $urandom(), 1'b0);
    repeat (5) queue_op(CMD_REMOVE, rand_key(), $urandom(), 1'b0);
    // deleted slots are reused
    for (j = 0; j < 12; j++) begin
      k = rand_key();
      filled.insert(filled.size(), k);
      queue_op(CMD_INSERT, k, $urandom(), 1'b0);
    end
    while (filled.size() != 0) begin
      j = $urandom_range(0, filled.size() - 1);
      queue_op(CMD_REMOVE, filled[j], $urandom(), 1'b0);
      filled.delete(j);
    end
  endtask

  // stimulus and end of test
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mirror_key[i]   = '0;
      mirror_value[i] = '0;
      mirror_state[i] = SLOT_EMPTY;
    end
    mirror_count = 0;

    // directed: empty table, extremes of key and value, collisions, update,
    // deleted markers on search and insert, double remove, unused command
    queue_op(CMD_SEARCH, '0, $urandom(), 1'b0);
    queue_op(CMD_REMOVE, '0, $urandom(), 1'b0);
    queue_op(CMD_INSERT, '0, '0, 1'b0);
    queue_op(CMD_INSERT, KEY_MAX, '1, 1'b0);
    queue_op(CMD_SEARCH, '0, $urandom(), 1'b0);
    queue_op(CMD_SEARCH, KEY_MAX, $urandom(), 1'b0);
    queue_op(CMD_INSERT, KEY_W'(31), 32'hA5A5_A5A5, 1'b0);    // same first slot as key 0
    queue_op(CMD_INSERT, KEY_W'(930), 32'h5A5A_5A5A, 1'b0);   // same chain as key 0
    queue_op(CMD_INSERT, '0, 32'h1234_5678, 1'b0);            // update in place
    queue_op(CMD_SEARCH, KEY_W'(930), $urandom(), 1'b0);
    queue_op(CMD_REMOVE, '0, $urandom(), 1'b0);
    queue_op(CMD_SEARCH, KEY_W'(31), $urandom(), 1'b0);       // passes the deleted slot
    queue_op(CMD_SEARCH, '0, $urandom(), 1'b0);
    queue_op(CMD_REMOVE, '0, $urandom(), 1'b0);
    queue_op(CMD_INSERT, KEY_W'(930), '1, 1'b0);              // found beyond the deleted slot
    queue_op(CMD_INSERT, KEY_W'(1860), 32'h8000_0001, 1'b0);  // reuses the deleted slot
    queue_op(CMD_SEARCH, KEY_W'(1860), $urandom(), 1'b0);
    queue_op(CMD_UNUSED, KEY_W'(930), $urandom(), 1'b0);
    queue_op(CMD_SEARCH, KEY_W'(930), $urandom(), 1'b0);
    queue_op(CMD_REMOVE, KEY_MAX, $urandom(), 1'b0);
    queue_op(CMD_SEARCH, KEY_MAX, $urandom(), 1'b0);

    repeat (6) add_mixed_phase(40);
    add_fill_phase();
    repeat (2) add_mixed_phase(40);
    ops_total = op_backlog.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (ops_accepted != ops_total || awaited_replies.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // command driver: bursts and gaps, holds a command until it transfers
  always @(negedge clk) begin : cmd_driver
    table_op_t next_op;
    if (rst_n && !(cmd_valid && !cmd_fire)) begin
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        cmd_valid <= 1'b0;
      end else if (op_backlog.size() != 0 &&
                   !(op_backlog[0].drain && awaited_replies.size() != 0)) begin
        next_op = op_backlog.pop_front();
        cmd_cur   <= next_op;
        cmd_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 12);
          // a third of the bursts run straight into the next one
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // reply receiver: stall pattern follows the top bits of a phase counter, plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      ready_phase <= ready_phase + 1'b1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_count >= 120 && cmd_valid) begin
        // sender keeps offering while replies back up into the block
        hold_left <= LONG_HOLD;
        hold_done <= 1'b1;
        rsp_ready <= 1'b0;
      end else begin
        case (ready_phase[7:6])
          2'd0: rsp_ready <= 1'b1;
          2'd1: rsp_ready <= 1'($urandom_range(0, 1));
          2'd2: rsp_ready <= (ready_phase[1:0] == 2'd0);
          default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // scoreboard: reply check first, then prediction for a command transfer on the same edge
  always @(posedge clk) begin : scoreboard
    table_reply_t want;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (rsp_bus.valid && rsp_ready) begin
        rsp_count++;
        if (awaited_replies.size() == 0) begin
          $error("reply transfer with nothing outstanding: status %0d slot %0d",
                 rsp_bus.status, rsp_bus.slot);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            fail_count++;
          end
          if (rsp_bus.found_value !== want.found_value) begin
            $error("found_value: expected 0x%08h, got 0x%08h",
                   want.found_value, rsp_bus.found_value);
            fail_count++;
          end
          if (rsp_bus.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, rsp_bus.slot);
            fail_count++;
          end
        end
      end
      cmd_fire <= cmd_valid && cmd_bus.ready;
      if (cmd_valid && cmd_bus.ready) begin
        awaited_replies.insert(awaited_replies.size(), table_predict(cmd_cur));
        ops_accepted++;
      end
    end
  end

endmodule
